### src/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/rlt_pkg.sv
package rlt_pkg;

  localparam int unsigned LOCK_SLOTS = 8;
  localparam int unsigned SLOT_IW    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(LOCK_SLOTS + 1);

  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(LOCK_SLOTS - 1);
  localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(LOCK_SLOTS);

  localparam int unsigned COORD_W = 13;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned CFG_IW  = 3;

  // config register indices
  localparam logic [CFG_IW-1:0] CFG_SURFACE_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SURFACE_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ROW_PITCH      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BYTES_PER_PIX  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BASE_ADDRESS   = 3'd4;

  typedef enum logic [1:0] {
    ACT_ADD        = 2'd0,
    ACT_REMOVE     = 2'd1,
    ACT_CHECK_RECT = 2'd2,
    ACT_CHECK_ADDR = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MAXLOCKED = 3'd1,
    ST_BUSY      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_LOCKED    = 3'd4,
    ST_UNLOCKED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic               whole_surface;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_right;
    logic [COORD_W-1:0] rect_bottom;
    logic [ADDR_W-1:0]  lock_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic              any_locked;
  } rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    rect_t             rect;
  } slot_entry_t;

  typedef struct packed {
    logic               en;
    logic               rect_en;
    logic [SLOT_IW-1:0] idx;
    slot_entry_t        entry;
  } slot_wr_t;

  typedef struct packed {
    logic overlap;
    logic amatch;
    logic free;
  } cmp_res_t;

endpackage

### src/rlt_slots.sv
module rlt_slots (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rlt_pkg::SLOT_IW-1:0]   rd_idx_i,
  output rlt_pkg::slot_entry_t          rd_entry_o,
  input  rlt_pkg::slot_wr_t             wr_i
);

  logic [rlt_pkg::ADDR_W-1:0] addr_q [rlt_pkg::LOCK_SLOTS];
  rlt_pkg::rect_t             rect_q [rlt_pkg::LOCK_SLOTS];

  // zero address marks a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(rlt_pkg::LOCK_SLOTS); i++) begin
        addr_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      addr_q[wr_i.idx] <= wr_i.entry.addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.rect_en) begin
      rect_q[wr_i.idx] <= wr_i.entry.rect;
    end
  end

  assign rd_entry_o.addr = addr_q[rd_idx_i];
  assign rd_entry_o.rect = rect_q[rd_idx_i];

endmodule

### src/rlt_cmp.sv
module rlt_cmp (
  input  rlt_pkg::slot_entry_t        entry_i,
  input  rlt_pkg::rect_t              rect_i,
  input  logic [rlt_pkg::ADDR_W-1:0]  addr_i,
  output rlt_pkg::cmp_res_t           res_o
);

  logic held;
  logic ovl;

  assign held = (entry_i.addr != '0);

  // half-open rectangles; an empty one is not excluded and may still overlap
  assign ovl = (entry_i.rect.left < rect_i.right) && (rect_i.left < entry_i.rect.right) &&
               (entry_i.rect.top < rect_i.bottom) && (rect_i.top < entry_i.rect.bottom);

  assign res_o.overlap = held && ovl;
  assign res_o.amatch  = (entry_i.addr == addr_i);
  assign res_o.free    = !held;

endmodule

### src/rlt_agen.sv
module rlt_agen (
  input  logic                          clk_i,
  input  logic [rlt_pkg::COORD_W-1:0]   top_i,
  input  logic [rlt_pkg::COORD_W-1:0]   left_i,
  input  logic [rlt_pkg::PITCH_W-1:0]   pitch_i,
  input  logic [rlt_pkg::BPP_W-1:0]     bpp_i,
  input  logic [rlt_pkg::ADDR_W-1:0]    base_i,
  output logic [rlt_pkg::ADDR_W-1:0]    addr_o
);

  localparam int unsigned ROW_W = rlt_pkg::COORD_W + rlt_pkg::PITCH_W;
  localparam int unsigned COL_W = rlt_pkg::COORD_W + rlt_pkg::BPP_W;

  logic [ROW_W-1:0] row_off_q;
  logic [COL_W-1:0] col_off_q;

  // products registered, sum taken in the following cycle
  always_ff @(posedge clk_i) begin
    row_off_q <= ROW_W'(top_i) * ROW_W'(pitch_i);
    col_off_q <= COL_W'(left_i) * COL_W'(bpp_i);
  end

  assign addr_o = base_i + rlt_pkg::ADDR_W'(row_off_q) + rlt_pkg::ADDR_W'(col_off_q);

endmodule

### src/region_lock_table.sv
// Region lock table: keeps up to LOCK_SLOTS locked rectangles of a frame buffer.
// Request channel: in_valid_i / in_stall_o carry an action (add, remove, check
// rectangle, check address) with a rectangle and an address. Response channel:
// out_valid_o / out_stall_i carry status, granted address and any-locked flag.
// A request is taken when valid is high and stall is low.
// Each request walks all slots once through one shared compare unit, one slot
// per cycle, then finishes the address sum in S_AGEN and decides in S_FIN.
// Requests are stalled until the block is back in idle; the response becomes
// valid as it returns there, and a new request can be taken in that cycle.
// The response sits in an output register, so the next request is taken while
// a response waits; if the receiver still stalls when the next one is
// decided, the block holds in its decision state and keeps stalling requests.
// Reset empties every slot, restores the default surface configuration and
// drops any pending response. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at once and are meant for idle periods only.
`include "assert_macros.svh"

module region_lock_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlt_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [rlt_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rlt_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rlt_pkg::rsp_t                 out_rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_AGEN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [rlt_pkg::COORD_W-1:0] surf_w_q, surf_h_q;
  logic [rlt_pkg::PITCH_W-1:0] pitch_q;
  logic [rlt_pkg::BPP_W-1:0]   bpp_q;
  logic [rlt_pkg::ADDR_W-1:0]  base_q;

  // latched request
  rlt_pkg::action_e           action_q;
  rlt_pkg::rect_t             rect_q;
  rlt_pkg::rect_t             rect_d;
  logic [rlt_pkg::ADDR_W-1:0] addr_q;

  // scan results
  logic [rlt_pkg::SLOT_IW-1:0] idx_q;
  logic                        hit_q, mfound_q, ffound_q;
  logic [rlt_pkg::SLOT_IW-1:0] midx_q, fidx_q;

  // table occupancy
  logic [rlt_pkg::CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic                      held_q, held_d;

  // response register
  logic          out_valid_q;
  rlt_pkg::rsp_t out_rsp_q, rsp_d;

  rlt_pkg::slot_entry_t       rd_entry;
  rlt_pkg::slot_wr_t          slot_wr;
  rlt_pkg::cmp_res_t          cmp_res;
  logic [rlt_pkg::ADDR_W-1:0] gen_addr;

  logic accept, fin_go;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign fin_go      = (state_q == S_FIN) && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  rlt_slots u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (rd_entry),
    .wr_i       (slot_wr)
  );

  rlt_cmp u_cmp (
    .entry_i (rd_entry),
    .rect_i  (rect_q),
    .addr_i  (addr_q),
    .res_o   (cmp_res)
  );

  rlt_agen u_agen (
    .clk_i   (clk_i),
    .top_i   (rect_q.top),
    .left_i  (rect_q.left),
    .pitch_i (pitch_q),
    .bpp_i   (bpp_q),
    .base_i  (base_q),
    .addr_o  (gen_addr)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= rlt_pkg::COORD_W'(640);
      surf_h_q <= rlt_pkg::COORD_W'(480);
      pitch_q  <= rlt_pkg::PITCH_W'(1280);
      bpp_q    <= rlt_pkg::BPP_W'(2);
      base_q   <= rlt_pkg::ADDR_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlt_pkg::CFG_SURFACE_WIDTH:  surf_w_q <= cfg_data_i[rlt_pkg::COORD_W-1:0];
        rlt_pkg::CFG_SURFACE_HEIGHT: surf_h_q <= cfg_data_i[rlt_pkg::COORD_W-1:0];
        rlt_pkg::CFG_ROW_PITCH:      pitch_q  <= cfg_data_i[rlt_pkg::PITCH_W-1:0];
        rlt_pkg::CFG_BYTES_PER_PIX:  bpp_q    <= cfg_data_i[rlt_pkg::BPP_W-1:0];
        rlt_pkg::CFG_BASE_ADDRESS:   base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole-surface requests use the configured extent
  always_comb begin
    if (in_req_i.whole_surface) begin
      rect_d.left   = '0;
      rect_d.top    = '0;
      rect_d.right  = surf_w_q;
      rect_d.bottom = surf_h_q;
    end else begin
      rect_d.left   = in_req_i.rect_left;
      rect_d.top    = in_req_i.rect_top;
      rect_d.right  = in_req_i.rect_right;
      rect_d.bottom = in_req_i.rect_bottom;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= rlt_pkg::action_e'(in_req_i.action);
      rect_q   <= rect_d;
      addr_q   <= in_req_i.lock_address;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (idx_q == rlt_pkg::LAST_SLOT) state_d = S_AGEN;
      S_AGEN:  state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slot walk: overlap hit, first address match, first free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      mfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else if (accept) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      mfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else if (state_q == S_SCAN) begin
      if (idx_q != rlt_pkg::LAST_SLOT) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmp_res.overlap) begin
        hit_q <= 1'b1;
      end
      if (cmp_res.amatch && !mfound_q) begin
        mfound_q <= 1'b1;
      end
      if (cmp_res.free && !ffound_q) begin
        ffound_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      if (cmp_res.amatch && !mfound_q) begin
        midx_q <= idx_q;
      end
      if (cmp_res.free && !ffound_q) begin
        fidx_q <= idx_q;
      end
    end
  end

  // decision
  always_comb begin
    free_cnt_d              = free_cnt_q;
    held_d                  = held_q;
    rsp_d.status            = rlt_pkg::ST_OK;
    rsp_d.granted_address   = '0;
    slot_wr.en              = 1'b0;
    slot_wr.rect_en         = 1'b0;
    slot_wr.idx             = fidx_q;
    slot_wr.entry.addr      = gen_addr;
    slot_wr.entry.rect      = rect_q;
    case (action_q)
      rlt_pkg::ACT_ADD: begin
        if (free_cnt_q == '0) begin
          rsp_d.status = rlt_pkg::ST_MAXLOCKED;
        end else if (hit_q) begin
          rsp_d.status = rlt_pkg::ST_BUSY;
        end else if (gen_addr == '0) begin
          // zero would read back as a free slot
          rsp_d.status = rlt_pkg::ST_INVALID;
        end else if (ffound_q) begin
          slot_wr.en            = fin_go;
          slot_wr.rect_en       = 1'b1;
          free_cnt_d            = free_cnt_q - 1'b1;
          held_d                = 1'b1;
          rsp_d.granted_address = gen_addr;
        end
      end
      rlt_pkg::ACT_REMOVE: begin
        slot_wr.idx        = midx_q;
        slot_wr.entry.addr = '0;
        if (addr_q == '0) begin
          rsp_d.status = rlt_pkg::ST_INVALID;
        end else if (mfound_q) begin
          slot_wr.en = fin_go;
          if (free_cnt_q < rlt_pkg::SLOTS_CNT) begin
            free_cnt_d = free_cnt_q + 1'b1;
          end
          if (free_cnt_d == rlt_pkg::SLOTS_CNT) begin
            held_d = 1'b0;
          end
        end
      end
      rlt_pkg::ACT_CHECK_RECT: begin
        rsp_d.status = hit_q ? rlt_pkg::ST_LOCKED : rlt_pkg::ST_UNLOCKED;
      end
      rlt_pkg::ACT_CHECK_ADDR: begin
        if (addr_q == '0) begin
          rsp_d.status = rlt_pkg::ST_INVALID;
        end else begin
          rsp_d.status = mfound_q ? rlt_pkg::ST_LOCKED : rlt_pkg::ST_UNLOCKED;
        end
      end
      default: ;
    endcase
    rsp_d.any_locked = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= rlt_pkg::SLOTS_CNT;
      held_q     <= 1'b0;
    end else if (fin_go) begin
      free_cnt_q <= free_cnt_d;
      held_q     <= held_d;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_rsp_q <= rsp_d;
    end
  end

  `ASSERT_IMP(a_held_matches_count, 1'b1, held_q == (free_cnt_q != rlt_pkg::SLOTS_CNT))
  `ASSERT_IMP(a_count_in_range, 1'b1, free_cnt_q <= rlt_pkg::SLOTS_CNT)
  `ASSERT_IMP(a_write_only_at_decision, slot_wr.en, fin_go)
  `ASSERT_NXT(a_accept_starts_walk, accept, (state_q == S_SCAN) && (idx_q == '0))
  `ASSERT_IMP(a_grant_only_on_ok, out_valid_q && (out_rsp_q.granted_address != '0), out_rsp_q.status == rlt_pkg::ST_OK)

endmodule

### verif/region_lock_table_tb.sv
`timescale 1ns / 1ps

// Testbench for the region lock table.
// A request (add, remove, check rectangle, check address) goes in on the
// valid/stall channel. Exactly one response comes back for each request.
// A local copy of the lock table predicts each response when its request is
// accepted, and queues it. The response checker compares every accepted
// response, field by field, with the oldest queued prediction.
// Inputs change on the falling edge. Handshakes are sampled on the rising edge.
module region_lock_table_tb;
  import rlt_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [ADDR_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  req_t              in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rsp_t              out_rsp_o;

  region_lock_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the lock table and its surface settings
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] surf_w;
  logic [COORD_W-1:0] surf_h;
  logic [PITCH_W-1:0] pitch_q;
  logic [BPP_W-1:0]   bpp_q;
  logic [ADDR_W-1:0]  base_q;

  logic [ADDR_W-1:0]  slot_addr [LOCK_SLOTS];  // zero marks a free slot
  rect_t              slot_area [LOCK_SLOTS];
  int                 free_cnt;
  logic               held_q;

  rsp_t owed_responses [$];  // predicted responses, oldest first
  int   mismatch_cnt = 0;
  bit   quiet = 1'b0;        // no gaps and no stalls while set
  int   stall_hold = 0;      // cycles to hold off the next response

  // Half-open overlap; an empty rectangle is not excluded and may still overlap.
  function automatic bit rect_overlaps(rect_t a, rect_t b);
    return a.left < b.right && b.left < a.right && a.top < b.bottom && b.top < a.bottom;
  endfunction

  function automatic bit area_is_held(rect_t area);
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (slot_addr[i] != '0 && rect_overlaps(slot_area[i], area)) return 1'b1;
    return 1'b0;
  endfunction

  // Lowest slot holding addr; with addr zero this finds the first free slot.
  function automatic int slot_holding(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (slot_addr[i] == addr) return i;
    return -1;
  endfunction

  // Applies one request to the local table and returns the response it owes.
  function automatic rsp_t apply_lock_request(req_t rq);
    rsp_t              rs;
    rect_t             area;
    logic [ADDR_W-1:0] top32;
    logic [ADDR_W-1:0] left32;
    logic [ADDR_W-1:0] pitch32;
    logic [ADDR_W-1:0] bpp32;
    logic [ADDR_W-1:0] start;
    int                idx;
    rs = '0;
    rs.status = ST_OK;
    if (rq.whole_surface) begin
      area.left   = '0;
      area.top    = '0;
      area.right  = surf_w;
      area.bottom = surf_h;
    end else begin
      area.left   = rq.rect_left;
      area.top    = rq.rect_top;
      area.right  = rq.rect_right;
      area.bottom = rq.rect_bottom;
    end
    case (action_e'(rq.action))
      ACT_ADD: begin
        if (free_cnt == 0) begin
          rs.status = ST_MAXLOCKED;
        end else if (area_is_held(area)) begin
          rs.status = ST_BUSY;
        end else begin
          top32   = ADDR_W'(area.top);
          left32  = ADDR_W'(area.left);
          pitch32 = ADDR_W'(pitch_q);
          bpp32   = ADDR_W'(bpp_q);
          start   = base_q + top32 * pitch32 + left32 * bpp32;  // wraps mod 2^32
          if (start == '0) begin
            // zero would read as a free slot, so nothing is stored
            rs.status = ST_INVALID;
          end else begin
            idx = slot_holding('0);
            slot_addr[idx] = start;
            slot_area[idx] = area;
            free_cnt--;
            held_q = 1'b1;
            rs.granted_address = start;
          end
        end
      end
      ACT_REMOVE: begin
        if (rq.lock_address == '0) begin
          rs.status = ST_INVALID;
        end else begin
          idx = slot_holding(rq.lock_address);
          if (idx >= 0) begin
            slot_addr[idx] = '0;
            if (free_cnt < LOCK_SLOTS) free_cnt++;
            if (free_cnt == LOCK_SLOTS) held_q = 1'b0;
          end
        end
      end
      ACT_CHECK_RECT: begin
        rs.status = area_is_held(area) ? ST_LOCKED : ST_UNLOCKED;
      end
      default: begin
        if (rq.lock_address == '0) rs.status = ST_INVALID;
        else rs.status = (slot_holding(rq.lock_address) >= 0) ? ST_LOCKED : ST_UNLOCKED;
      end
    endcase
    rs.any_locked = held_q;
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic rect_t mk_area(logic [COORD_W-1:0] l, t, r, b);
    rect_t a;
    a.left   = l;
    a.top    = t;
    a.right  = r;
    a.bottom = b;
    return a;
  endfunction

  function automatic req_t mk_req(action_e act, logic whole, rect_t area,
                                  logic [ADDR_W-1:0] addr);
    req_t rq;
    rq.action        = act;
    rq.whole_surface = whole;
    rq.rect_left     = area.left;
    rq.rect_top      = area.top;
    rq.rect_right    = area.right;
    rq.rect_bottom   = area.bottom;
    rq.lock_address  = addr;
    return rq;
  endfunction

  // Mostly small rectangles on a tight grid, so overlaps and a full table
  // are common; now and then an empty or a wild one.
  function automatic rect_t random_area();
    int l;
    int t;
    int k;
    k = $urandom_range(0, 19);
    l = $urandom_range(0, 120);
    t = $urandom_range(0, 120);
    if (k == 0)
      return mk_area(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                     13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
    if (k == 1)
      return mk_area(13'(l), 13'(t), 13'($urandom_range(0, l)), 13'(t + 4));
    return mk_area(13'(l), 13'(t), 13'(l + $urandom_range(1, 24)),
                   13'(t + $urandom_range(1, 24)));
  endfunction

  // A held address most of the time, else zero or a stray value.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] held [$];
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (slot_addr[i] != '0) held.push_back(slot_addr[i]);
    if (held.size() > 0 && $urandom_range(0, 4) != 0)
      return held[$urandom_range(0, held.size() - 1)];
    if ($urandom_range(0, 4) == 0) return '0;
    return $urandom;
  endfunction

  function automatic req_t random_request();
    int         roll;
    logic       whole;
    logic [95:0] raw;
    roll  = $urandom_range(0, 99);
    whole = ($urandom_range(0, 19) == 0);
    if (roll < 38) return mk_req(ACT_ADD, whole, random_area(), $urandom);
    if (roll < 63)
      return mk_req(ACT_REMOVE, 1'($urandom_range(0, 1)), random_area(), pick_address());
    if (roll < 78) return mk_req(ACT_CHECK_RECT, whole, random_area(), $urandom);
    if (roll < 93)
      return mk_req(ACT_CHECK_ADDR, 1'($urandom_range(0, 1)), random_area(), pick_address());
    // noise: every bit of the request drawn at random
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Entered and left on a falling edge. Valid stays high on return, so a
  // back-to-back request follows with no gap; anything else lowers it first.
  task automatic issue_request(req_t rq);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   = rq;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    owed_responses.push_back(apply_lock_request(rq));
    @(negedge clk_i);
  endtask

  task automatic wait_all_answered();
    in_valid_i = 1'b0;
    while (owed_responses.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [ADDR_W-1:0] val);
    in_valid_i = 1'b0;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SURFACE_WIDTH:  surf_w  = val[COORD_W-1:0];
      CFG_SURFACE_HEIGHT: surf_h  = val[COORD_W-1:0];
      CFG_ROW_PITCH:      pitch_q = val[PITCH_W-1:0];
      CFG_BYTES_PER_PIX:  bpp_q   = val[BPP_W-1:0];
      CFG_BASE_ADDRESS:   base_q  = val;
      default: ;
    endcase
  endtask

  // Registers change only once the block has answered everything.
  task automatic set_surface(logic [COORD_W-1:0] w, h, logic [PITCH_W-1:0] pitch,
                             logic [BPP_W-1:0] bpp, logic [ADDR_W-1:0] base);
    wait_all_answered();
    cfg_write(CFG_SURFACE_WIDTH, ADDR_W'(w));
    cfg_write(CFG_SURFACE_HEIGHT, ADDR_W'(h));
    cfg_write(CFG_ROW_PITCH, ADDR_W'(pitch));
    cfg_write(CFG_BYTES_PER_PIX, ADDR_W'(bpp));
    cfg_write(CFG_BASE_ADDRESS, base);
  endtask

  task automatic clear_all_locks();
    logic [ADDR_W-1:0] held [LOCK_SLOTS];
    for (int i = 0; i < LOCK_SLOTS; i++) held[i] = slot_addr[i];
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (held[i] != '0) issue_request(mk_req(ACT_REMOVE, 1'b0, '0, held[i]));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    // bad address on both address actions; whole_surface must be ignored
    issue_request(mk_req(ACT_CHECK_ADDR, 1'b1, '0, '0));
    issue_request(mk_req(ACT_REMOVE, 1'b0, '0, '0));
    issue_request(mk_req(ACT_CHECK_RECT, 1'b1, '0, '0));
    issue_request(mk_req(ACT_ADD, 1'b1, '0, '0));
    // anything inside the whole surface is now busy
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd10, 13'd10, 13'd20, 13'd20), '0));
    issue_request(mk_req(ACT_CHECK_ADDR, 1'b0, '0, slot_addr[0]));
    issue_request(mk_req(ACT_REMOVE, 1'b1, '0, slot_addr[0]));
    // removing an address nobody holds is harmless
    issue_request(mk_req(ACT_REMOVE, 1'b0, '0, 32'h0000_1000));
    // empty rectangles at the far corner: same address twice
    issue_request(mk_req(ACT_ADD, 1'b0,
                         mk_area(13'd8191, 13'd8191, 13'd8191, 13'd8191), '1));
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd8191, 13'd8191, 13'd0, 13'd0), '0));
    issue_request(mk_req(ACT_CHECK_RECT, 1'b0,
                         mk_area(13'd0, 13'd0, 13'd8191, 13'd8191), '0));
    // duplicates go lowest slot first; any_locked only drops on the second
    issue_request(mk_req(ACT_REMOVE, 1'b0, '0, slot_addr[1]));
    issue_request(mk_req(ACT_REMOVE, 1'b0, '0, slot_addr[1]));
    // fill every slot with disjoint strips, then one too many
    for (int i = 0; i < LOCK_SLOTS; i++)
      issue_request(mk_req(ACT_ADD, 1'b0,
                           mk_area(13'(i * 8), 13'd0, 13'(i * 8 + 8), 13'd4), '0));
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd2, 13'd0, 13'd3, 13'd1), '0));
    // touching the last strip's right edge is not an overlap
    issue_request(mk_req(ACT_CHECK_RECT, 1'b0,
                         mk_area(13'(LOCK_SLOTS * 8), 13'd0, 13'd90, 13'd4), '0));
    issue_request(mk_req(ACT_CHECK_ADDR, 1'b0, '1, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      issue_request(random_request());
    end
    quiet = 1'b0;
  endtask

  // Range limits, then values past them at the full register widths.
  task automatic test_register_extremes();
    set_surface(13'd1, 13'd1, 15'd1, 3'd1, 32'd1);
    test_random_traffic(330);
    set_surface(13'd4096, 13'd4096, 15'd16384, 3'd4, 32'hFFFF_FFFF);
    test_random_traffic(330);
    // zero base: any grant at the origin comes back invalid
    set_surface(13'h1FFF, 13'd0, 15'h7FFF, 3'd7, 32'd0);
    test_random_traffic(330);
    // no pitch and no pixel size: every grant lands on the base address
    set_surface(13'd0, 13'd4095, 15'd0, 3'd0, 32'h8000_0000);
    test_random_traffic(330);
  endtask

  task automatic test_address_wrap();
    wait_all_answered();
    clear_all_locks();
    set_surface(13'd320, 13'd200, 15'd2, 3'd2, 32'hFFFF_FFFE);
    // left wraps to zero
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd1, 13'd0, 13'd3, 13'd1), '0));
    // top wraps to zero
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd0, 13'd1, 13'd1, 13'd2), '0));
    // past zero: fine
    issue_request(mk_req(ACT_ADD, 1'b0, mk_area(13'd2, 13'd0, 13'd4, 13'd1), '0));
    issue_request(mk_req(ACT_CHECK_ADDR, 1'b0, '0, 32'd2));
    test_random_traffic(150);
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [ADDR_W-1:0] want,
                                 logic [ADDR_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Stall only while a response is offered, so the hold is really felt;
  // a stray stall now and then while idle.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && stall_hold > 0) begin
        out_stall_i = 1'b1;
        stall_hold--;
      end else begin
        out_stall_i = !quiet && !out_valid_o && ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_hold = quiet ? 0 : $urandom_range(0, 12);
      if (owed_responses.size() == 0) begin
        report_mismatch("unrequested response", '0, ADDR_W'(out_rsp_o.status));
      end else begin
        want = owed_responses.pop_front();
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", ADDR_W'(want.status), ADDR_W'(out_rsp_o.status));
        if (out_rsp_o.granted_address !== want.granted_address)
          report_mismatch("granted_address", want.granted_address, out_rsp_o.granted_address);
        if (out_rsp_o.any_locked !== want.any_locked)
          report_mismatch("any_locked", ADDR_W'(want.any_locked),
                          ADDR_W'(out_rsp_o.any_locked));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock, run limit and sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("region_lock_table_tb: errors");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    surf_w     = 13'd640;
    surf_h     = 13'd480;
    pitch_q    = 15'd1280;
    bpp_q      = 3'd2;
    base_q     = 32'd4096;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      slot_addr[i] = '0;
      slot_area[i] = '0;
    end
    free_cnt = LOCK_SLOTS;
    held_q   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic(330);
    test_register_extremes();
    test_address_wrap();

    wait_all_answered();
    repeat (LOCK_SLOTS + 3) @(negedge clk_i);
    if (mismatch_cnt == 0 && owed_responses.size() == 0) begin
      $display("region_lock_table_tb: clean");
    end else begin
      $display("region_lock_table_tb: errors");
    end
    $finish;
  end

endmodule

### region_lock_table.f
+incdir+src
src/rlt_pkg.sv
src/rlt_slots.sv
src/rlt_cmp.sv
src/rlt_agen.sv
src/region_lock_table.sv
verif/region_lock_table_tb.sv
